// ===== sv/sqe_pkg.sv =====
// Shared types and codes for the stack/queue engine.
// Holds the transaction payload structs, operation and status codes and the
// controller state type. Depends on nothing.
package sqe_pkg;

    // Operation codes carried in the input mode field
    localparam logic [2:0] MODE_PUSH = 3'd0;
    localparam logic [2:0] MODE_SWAP = 3'd1;
    localparam logic [2:0] MODE_DUMP = 3'd2;
    localparam logic [2:0] MODE_POP  = 3'd3;
    localparam logic [2:0] MODE_PEEK = 3'd4;

    // Status codes reported with each result
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_ARG    = 3'd1;
    localparam logic [2:0] ST_SWAP_SHORT = 3'd2;
    localparam logic [2:0] ST_POP_EMPTY  = 3'd3;
    localparam logic [2:0] ST_PEEK_EMPTY = 3'd4;
    localparam logic [2:0] ST_FULL       = 3'd5;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] push_value;
        logic               arg_ok;
    } in_t;

    typedef struct packed {
        logic signed [31:0] data;
        logic               has_data;
        logic [2:0]         status;
        logic               last;
    } out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_PEEK,
        S_SWAP_B,
        S_SWAP_WA,
        S_SWAP_WB,
        S_DUMP
    } state_t;

endpackage

// ===== sv/sqe_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// Used for the value store of the stack/queue engine. No dependencies.
// A read of the address being written in the same cycle returns the old word.
module sqe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; hold the last word while no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/stack_queue_engine.sv =====
// Top level of the bounded stack/queue engine: controller and value store.
// Depends on sqe_pkg and sqe_ram.
//
//   channel   signals                          direction  transaction
//   in        in_valid, in_ready, in_data      input      one operation (in_t)
//   out       out_valid, out_ready, out_data   output     one result (out_t)
//   cfg       cfg_wr_en, cfg_wr_data           input      queue_mode write
//
// One operation is taken at a time; in_ready is high only while the controller
// is idle. A dump of N stored entries returns one result per entry, one entry
// per cycle while the output is not stalled, read through the RAM's single
// read port. Reset clears the top index, entry count, queue_mode and the
// output valid flag; RAM contents are left as they are. A stalled output
// holds the controller in its emitting state until the result is taken.
module stack_queue_engine #(
    parameter int DEPTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  sqe_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output sqe_pkg::out_t out_data,
    input  logic          cfg_wr_en,
    input  logic          cfg_wr_data
);

    import sqe_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    state_t          state_reg, state_next;
    in_t             op_reg, op_next;
    logic [AW-1:0]   top_reg, top_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   k_reg, k_next;
    logic [31:0]     tmp_reg, tmp_next;
    logic            qmode_reg;
    logic            out_valid_reg, out_valid_next;
    out_t            out_reg, out_next;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [31:0]     ram_wdata;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    logic [31:0]     ram_rdata;

    logic            accept;
    logic            out_free;
    logic            full;
    logic            dump_last;

    // Position of the k-th entry below the top, wrapped round the buffer
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] top,
                                              input logic [CW-1:0] k);
        logic [SW-1:0] sum;
        sum = SW'(top) + SW'(k);
        if (sum >= SW'(DEPTH))
        begin
            sum = sum - SW'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign full      = (count_reg == CW'(DEPTH));
    assign dump_last = (k_reg == count_reg - 1'b1);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (op_reg.mode)
                    MODE_PUSH, MODE_POP:
                    begin
                        if (out_free)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    MODE_SWAP:
                    begin
                        if (count_reg >= CW'(2))
                        begin
                            state_next = S_SWAP_B;
                        end
                        else if (out_free)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    MODE_DUMP:
                    begin
                        if (count_reg != '0)
                        begin
                            state_next = S_DUMP;
                        end
                        else if (out_free)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    MODE_PEEK:
                    begin
                        if (count_reg != '0)
                        begin
                            state_next = S_PEEK;
                        end
                        else if (out_free)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_PEEK, S_SWAP_WB:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SWAP_B:
            begin
                state_next = S_SWAP_WA;
            end
            S_SWAP_WA:
            begin
                state_next = S_SWAP_WB;
            end
            S_DUMP:
            begin
                if (out_free && dump_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath, RAM access and result generation
    always_comb
    begin
        op_next        = accept ? in_data : op_reg;
        top_next       = top_reg;
        count_next     = count_reg;
        k_next         = k_reg;
        tmp_next       = tmp_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_waddr      = slot_of(top_reg, '0);
        ram_wdata      = op_reg.push_value;
        ram_re         = 1'b0;
        ram_raddr      = slot_of(top_reg, '0);

        unique case (state_reg)
            S_EXEC:
            begin
                unique case (op_reg.mode)
                    MODE_PUSH:
                    begin
                        if (out_free)
                        begin
                            out_valid_next    = 1'b1;
                            out_next.data     = '0;
                            out_next.has_data = 1'b0;
                            out_next.last     = 1'b1;
                            if (!op_reg.arg_ok)
                            begin
                                out_next.status = ST_BAD_ARG;
                            end
                            else if (full)
                            begin
                                out_next.status = ST_FULL;
                            end
                            else
                            begin
                                out_next.status = ST_OK;
                                ram_we          = 1'b1;
                                count_next      = count_reg + 1'b1;
                                if (qmode_reg)
                                begin
                                    ram_waddr = slot_of(top_reg, count_reg);
                                end
                                else
                                begin
                                    top_next  = (top_reg == '0) ? AW'(DEPTH - 1)
                                                                : top_reg - 1'b1;
                                    ram_waddr = top_next;
                                end
                            end
                        end
                    end
                    MODE_POP:
                    begin
                        if (out_free)
                        begin
                            out_valid_next    = 1'b1;
                            out_next.data     = '0;
                            out_next.has_data = 1'b0;
                            out_next.last     = 1'b1;
                            if (count_reg == '0)
                            begin
                                out_next.status = ST_POP_EMPTY;
                            end
                            else
                            begin
                                out_next.status = ST_OK;
                                top_next        = slot_of(top_reg, CW'(1));
                                count_next      = count_reg - 1'b1;
                            end
                        end
                    end
                    MODE_SWAP:
                    begin
                        if (count_reg >= CW'(2))
                        begin
                            ram_re = 1'b1;
                        end
                        else if (out_free)
                        begin
                            out_valid_next    = 1'b1;
                            out_next.data     = '0;
                            out_next.has_data = 1'b0;
                            out_next.status   = ST_SWAP_SHORT;
                            out_next.last     = 1'b1;
                        end
                    end
                    MODE_DUMP:
                    begin
                        if (count_reg != '0)
                        begin
                            ram_re = 1'b1;
                            k_next = '0;
                        end
                        else if (out_free)
                        begin
                            out_valid_next    = 1'b1;
                            out_next.data     = '0;
                            out_next.has_data = 1'b0;
                            out_next.status   = ST_OK;
                            out_next.last     = 1'b1;
                        end
                    end
                    MODE_PEEK:
                    begin
                        if (count_reg != '0)
                        begin
                            ram_re = 1'b1;
                        end
                        else if (out_free)
                        begin
                            out_valid_next    = 1'b1;
                            out_next.data     = '0;
                            out_next.has_data = 1'b0;
                            out_next.status   = ST_PEEK_EMPTY;
                            out_next.last     = 1'b1;
                        end
                    end
                    default:
                    begin
                        // Undefined operation: drop it
                    end
                endcase
            end
            S_PEEK:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_next.data     = ram_rdata;
                    out_next.has_data = 1'b1;
                    out_next.status   = ST_OK;
                    out_next.last     = 1'b1;
                end
            end
            S_SWAP_B:
            begin
                // Hold the top word, fetch the one below it
                tmp_next  = ram_rdata;
                ram_re    = 1'b1;
                ram_raddr = slot_of(top_reg, CW'(1));
            end
            S_SWAP_WA:
            begin
                ram_we    = 1'b1;
                ram_waddr = slot_of(top_reg, '0);
                ram_wdata = ram_rdata;
            end
            S_SWAP_WB:
            begin
                ram_we    = 1'b1;
                ram_waddr = slot_of(top_reg, CW'(1));
                ram_wdata = tmp_reg;
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_next.data     = '0;
                    out_next.has_data = 1'b0;
                    out_next.status   = ST_OK;
                    out_next.last     = 1'b1;
                end
            end
            S_DUMP:
            begin
                // Emit one entry and fetch the next in the same cycle
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_next.data     = ram_rdata;
                    out_next.has_data = 1'b1;
                    out_next.status   = ST_OK;
                    out_next.last     = dump_last;
                    if (!dump_last)
                    begin
                        k_next    = k_reg + 1'b1;
                        ram_re    = 1'b1;
                        ram_raddr = slot_of(top_reg, k_next);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            top_reg       <= '0;
            count_reg     <= '0;
            k_reg         <= '0;
            qmode_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            count_reg     <= count_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                qmode_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        tmp_reg <= tmp_next;
        out_reg <= out_next;
    end

    sqe_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

// ===== sv/sqe_checker.sv =====
// Port-level checks for the stack/queue engine, bound to its top level.
// Depends on sqe_pkg and stack_queue_engine.
module sqe_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input sqe_pkg::out_t out_data
);

    import sqe_pkg::*;

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed or dropped");

    // Take one operation at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second operation accepted while one is in flight");

    // Only a stored value may continue a dump
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.has_data |-> out_data.last)
        else $error("result without data is not marked last");

    // A stored value is only ever reported with an ok status
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.has_data |-> out_data.status == ST_OK)
        else $error("data result carries an error status");

endmodule

bind stack_queue_engine sqe_checker u_sqe_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
);

// ===== tb/tb_stack_queue_engine.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for stack_queue_engine: directed and random store operations
// in stack and queue mode, checked against an in-bench prediction of the store.
// Depends on sqe_pkg and the stack_queue_engine RTL.
module tb_stack_queue_engine;
    import sqe_pkg::*;

    localparam int  DEPTH      = 32;
    localparam real CLK_HALF   = 6.0;
    localparam int  RESET_CYC  = 6;
    localparam int  PHASES     = 8;
    localparam int  PHASE_OPS  = 26;
    localparam real LIMIT_NS   = 50_000_000.0;

    // Bias of a random phase towards growing or shrinking the store
    localparam int BIAS_GROW   = 0;
    localparam int BIAS_MIXED  = 1;
    localparam int BIAS_SHRINK = 2;

    logic  clk;
    logic  rst_n       = 1'b0;
    logic  in_valid    = 1'b0;
    logic  in_ready;
    in_t   in_data     = '0;
    logic  out_valid;
    logic  out_ready   = 1'b0;
    out_t  out_data;
    logic  cfg_wr_en   = 1'b0;
    logic  cfg_wr_data = 1'b0;

    // Driver and monitor bookkeeping
    in_t   pending_ops[$];
    out_t  awaited_results[$];
    int    gap_left;
    int    stall_left;
    bit    quiet;
    int    mismatch_count;
    int    result_seq;
    out_t  want_res;

    // Predicted store contents
    logic signed [31:0] held_vals[DEPTH];
    int    top_pos;
    int    held_count;
    bit    queue_mode_model;

    stack_queue_engine #(.DEPTH(DEPTH)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("Simulation FAILED");
        $finish;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet)
            return 0;
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic in_t make_op(logic [2:0] m, logic [31:0] v, logic ok);
        in_t it;
        it.mode       = m;
        it.push_value = v;
        it.arg_ok     = ok;
        return it;
    endfunction

    // Random operation; unused fields carry noise
    function automatic in_t random_op(int bias);
        in_t it;
        int  push_pct;
        int  r;
        push_pct      = (bias == BIAS_GROW) ? 65 : (bias == BIAS_MIXED) ? 35 : 15;
        it.push_value = $urandom;
        it.arg_ok     = 1'($urandom_range(0, 1));
        r             = $urandom_range(0, 99);
        if (r < push_pct)
        begin
            it.mode   = MODE_PUSH;
            it.arg_ok = ($urandom_range(0, 9) != 0);
            case ($urandom_range(0, 15))
                0: it.push_value = 32'h8000_0000;
                1: it.push_value = 32'h7fff_ffff;
                2: it.push_value = 32'h0000_0000;
                3: it.push_value = 32'hffff_ffff;
                default: ;
            endcase
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                it.mode = MODE_POP;
            else if (r < 65)
                it.mode = MODE_PEEK;
            else if (r < 85)
                it.mode = MODE_SWAP;
            else if (r < 95)
                it.mode = MODE_DUMP;
            else
                it.mode = 3'($urandom_range(5, 7));
        end
        return it;
    endfunction

    // Advance the predicted store by one operation and queue its results
    task automatic predict_store_op(input in_t op);
        out_t               r;
        logic signed [31:0] tmp;
        int                 a;
        int                 b;
        r      = '0;
        r.last = 1'b1;
        case (op.mode)
            MODE_PUSH:
            begin
                if (!op.arg_ok)
                    r.status = ST_BAD_ARG;
                else if (held_count >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    if (queue_mode_model)
                        held_vals[(top_pos + held_count) % DEPTH] = op.push_value;
                    else
                    begin
                        top_pos = (top_pos + DEPTH - 1) % DEPTH;
                        held_vals[top_pos] = op.push_value;
                    end
                    held_count++;
                    r.status = ST_OK;
                end
                awaited_results.push_back(r);
            end
            MODE_SWAP:
            begin
                if (held_count < 2)
                    r.status = ST_SWAP_SHORT;
                else
                begin
                    a            = top_pos;
                    b            = (top_pos + 1) % DEPTH;
                    tmp          = held_vals[a];
                    held_vals[a] = held_vals[b];
                    held_vals[b] = tmp;
                    r.status     = ST_OK;
                end
                awaited_results.push_back(r);
            end
            MODE_DUMP:
            begin
                r.status = ST_OK;
                if (held_count == 0)
                    awaited_results.push_back(r);
                else
                    for (int k = 0; k < held_count; k++)
                    begin
                        r.data     = held_vals[(top_pos + k) % DEPTH];
                        r.has_data = 1'b1;
                        r.last     = (k == held_count - 1);
                        awaited_results.push_back(r);
                    end
            end
            MODE_POP:
            begin
                if (held_count == 0)
                    r.status = ST_POP_EMPTY;
                else
                begin
                    top_pos = (top_pos + 1) % DEPTH;
                    held_count--;
                    r.status = ST_OK;
                end
                awaited_results.push_back(r);
            end
            MODE_PEEK:
            begin
                if (held_count == 0)
                    r.status = ST_PEEK_EMPTY;
                else
                begin
                    r.data     = held_vals[top_pos];
                    r.has_data = 1'b1;
                    r.status   = ST_OK;
                end
                awaited_results.push_back(r);
            end
            default: ;
        endcase
    endtask

    task automatic flag_mismatch(input string field, input logic [31:0] got_v,
                                 input logic [31:0] want_v);
        $display("[%0t] result %0d: %s mismatch, got %0h expected %0h",
                 $realtime, result_seq, field, got_v, want_v);
        mismatch_count++;
    endtask

    // Hold until the block is drained, then let it settle
    task automatic wait_drained(input int settle);
        do
            @(negedge clk);
        while (pending_ops.size() != 0 || in_valid || awaited_results.size() != 0);
        repeat (settle) @(negedge clk);
    endtask

    task automatic write_queue_mode(input bit m);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        queue_mode_model = m;
    endtask

    // Driver: present the next pending transaction after a random gap
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            gap_left <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_ops.size() != 0)
            begin
                in_valid <= 1'b1;
                in_data  <= pending_ops.pop_front();
                gap_left <= pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Monitor: predict on accepted operations, check accepted results, pace out_ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_store_op(in_data);
            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                    flag_mismatch("unexpected result", out_data.data, '0);
                else
                begin
                    want_res = awaited_results.pop_front();
                    if (out_data.data !== want_res.data)
                        flag_mismatch("data", out_data.data, want_res.data);
                    if (out_data.has_data !== want_res.has_data)
                        flag_mismatch("has_data", 32'(out_data.has_data),
                                      32'(want_res.has_data));
                    if (out_data.status !== want_res.status)
                        flag_mismatch("status", 32'(out_data.status),
                                      32'(want_res.status));
                    if (out_data.last !== want_res.last)
                        flag_mismatch("last", 32'(out_data.last), 32'(want_res.last));
                end
                result_seq++;
            end
            if (stall_left > 0)
            begin
                out_ready  <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 99) < 30)
                    stall_left <= pick_gap();
            end
        end
    end

    // Stimulus: reset, directed checks, then random phases per queue_mode setting
    initial
    begin
        int  n;
        int  bias;
        in_t it;

        mismatch_count   = 0;
        result_seq       = 0;
        top_pos          = 0;
        held_count       = 0;
        queue_mode_model = 1'b0;
        quiet            = 1'b0;
        foreach (held_vals[i])
            held_vals[i] = '0;

        repeat (RESET_CYC) @(posedge clk);
        rst_n <= 1'b1;

        // Empty store, bad argument, extremes, ignored modes, short swap
        pending_ops.push_back(make_op(MODE_PEEK, 32'h0, 1'b1));
        pending_ops.push_back(make_op(MODE_POP,  32'h0, 1'b1));
        pending_ops.push_back(make_op(MODE_SWAP, 32'h0, 1'b1));
        pending_ops.push_back(make_op(MODE_DUMP, 32'h0, 1'b1));
        pending_ops.push_back(make_op(MODE_PUSH, 32'h7fff_ffff, 1'b0));
        pending_ops.push_back(make_op(MODE_PUSH, 32'h8000_0000, 1'b1));
        pending_ops.push_back(make_op(MODE_SWAP, 32'h0, 1'b1));
        pending_ops.push_back(make_op(MODE_PUSH, 32'h7fff_ffff, 1'b1));
        pending_ops.push_back(make_op(MODE_PUSH, 32'h0, 1'b1));
        pending_ops.push_back(make_op(MODE_SWAP, 32'hffff_ffff, 1'b0));
        pending_ops.push_back(make_op(MODE_PEEK, 32'h0, 1'b0));
        pending_ops.push_back(make_op(MODE_DUMP, 32'h0, 1'b1));
        pending_ops.push_back(make_op(3'd5, 32'h1234_5678, 1'b1));
        pending_ops.push_back(make_op(3'd6, 32'hffff_ffff, 1'b1));
        pending_ops.push_back(make_op(3'd7, 32'h0, 1'b0));
        pending_ops.push_back(make_op(MODE_PUSH, 32'hffff_ffff, 1'b0));
        pending_ops.push_back(make_op(MODE_POP,  32'h0, 1'b1));
        pending_ops.push_back(make_op(MODE_PEEK, 32'h0, 1'b1));
        pending_ops.push_back(make_op(MODE_PUSH, 32'h5555_aaaa, 1'b1));
        pending_ops.push_back(make_op(MODE_DUMP, 32'h0, 1'b1));
        pending_ops.push_back(make_op(MODE_POP,  32'h0, 1'b1));
        pending_ops.push_back(make_op(MODE_POP,  32'h0, 1'b1));
        pending_ops.push_back(make_op(MODE_SWAP, 32'h0, 1'b1));
        pending_ops.push_back(make_op(MODE_POP,  32'h0, 1'b1));
        pending_ops.push_back(make_op(MODE_POP,  32'h0, 1'b1));
        pending_ops.push_back(make_op(MODE_DUMP, 32'h0, 1'b1));
        wait_drained(10);

        for (int p = 0; p < PHASES; p++)
        begin
            // Alternate queue and stack mode between phases, block idle
            write_queue_mode((p % 2) == 0);
            quiet = (p == 5);
            bias  = p % 3;

            // First two phases: fill past full, bad argument on a full store, dump
            if (p < 2)
            begin
                for (int k = 0; k < DEPTH + 2; k++)
                    pending_ops.push_back(make_op(MODE_PUSH, $urandom, 1'b1));
                pending_ops.push_back(make_op(MODE_PUSH, $urandom, 1'b0));
                pending_ops.push_back(make_op(MODE_DUMP, $urandom, 1'b0));
                pending_ops.push_back(make_op(MODE_SWAP, $urandom, 1'b1));
                pending_ops.push_back(make_op(MODE_PEEK, $urandom, 1'b1));
            end

            n = 0;
            while (n < PHASE_OPS)
            begin
                it = random_op(bias);
                pending_ops.push_back(it);
                if (it.mode <= MODE_PEEK)
                    n++;
            end
            wait_drained(10);
        end

        wait_drained(40);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== stack_queue_engine.f =====
sv/sqe_pkg.sv
sv/sqe_ram.sv
sv/stack_queue_engine.sv
sv/sqe_checker.sv
tb/tb_stack_queue_engine.sv
